@@ src/jsd_pkg.sv @@
// ----------------------------------------------------------------------------
// jsd_pkg: shared types and constants for the joint space distance block
// Word widths, the fixed-point pi constant and the sequencer state type.
// ----------------------------------------------------------------------------
package jsd_pkg;

  // Input word width and accumulator width
  localparam int unsigned WORD_W = 32;
  localparam int unsigned ACC_W  = 64;

  // Pi with 60 fraction bits, rounded at elaboration to the working scale
  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRAP,
    ST_MAG,
    ST_MULW,
    ST_RNDW,
    ST_MULS,
    ST_RNDS,
    ST_ACC,
    ST_FIN,
    ST_SQRT,
    ST_OUT
  } jsd_state_e;

endpackage

@@ src/jsd_mul.sv @@
// ----------------------------------------------------------------------------
// jsd_mul: shared 32x32 unsigned multiplier
// Product is registered; it is valid in the cycle after the operands.
// ----------------------------------------------------------------------------
module jsd_mul (
  input  logic                            clk_i,
  input  logic [jsd_pkg::WORD_W-1:0]      a_i,
  input  logic [jsd_pkg::WORD_W-1:0]      b_i,
  output logic [2*jsd_pkg::WORD_W-1:0]    p_o
);

  logic [2*jsd_pkg::WORD_W-1:0] p_q;

  // Register the product
  always_ff @(posedge clk_i) begin
    p_q <= (2*jsd_pkg::WORD_W)'(a_i) * (2*jsd_pkg::WORD_W)'(b_i);
  end

  assign p_o = p_q;

endmodule

@@ src/jsd_isqrt.sv @@
// ----------------------------------------------------------------------------
// jsd_isqrt: iterative integer square root
// Digit-by-digit root of a 64-bit operand, one result bit per cycle.
// ----------------------------------------------------------------------------
module jsd_isqrt (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [jsd_pkg::ACC_W-1:0]       operand_i,
  output logic                            done_o,
  output logic [jsd_pkg::WORD_W-1:0]      root_o
);

  logic                        busy_q;
  logic                        done_q;
  logic [jsd_pkg::ACC_W-1:0]   rem_q;
  logic [jsd_pkg::ACC_W-1:0]   res_q;
  logic [jsd_pkg::ACC_W-1:0]   bit_q;
  logic [jsd_pkg::ACC_W-1:0]   trial;

  assign trial = res_q + bit_q;

  // Control: run until the lowest bit position is done
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Datapath: load, then one compare-subtract per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= operand_i;
      res_q <= '0;
      bit_q <= jsd_pkg::ACC_W'(1) << (jsd_pkg::ACC_W - 2);
    end else if (busy_q) begin
      if (rem_q >= trial) begin
        rem_q <= rem_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[jsd_pkg::WORD_W-1:0];

endmodule

@@ src/joint_space_distance.sv @@
// ----------------------------------------------------------------------------
// joint_space_distance: weighted joint-space Euclidean distance
// Accumulates squared per-joint distances and returns their square root.
// ----------------------------------------------------------------------------
// One joint per input transfer; the block takes one joint at a time and is not
// ready while it works. After the accept, a plain (non-angular) joint passes
// through a magnitude step, a squaring pass through the shared multiplier with
// its rounding step, and an accumulate step. An angular joint adds a weight pass
// with its own rounding step before the square, and an angular circular joint
// first makes four wrap steps. A term that saturates skips the squaring pass.
// The joint marked with tlast adds a check step and, unless the sum is too large
// for the root, a run of the bit-per-cycle square root unit (32 steps and a done
// strobe); then the result waits in the output register until taken.
// The accumulator and overflow flag clear when the result is loaded.
// Positions are signed, weights and the distance unsigned, fixed point with FRAC_BITS fraction bits.
module joint_space_distance #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // tdata, lowest bit up: start_position[31:0], end_position[31:0],
  // joint_weight[31:0]
  input  logic [95:0]  s_axis_tdata_i,
  // tuser, lowest bit up: is_angular, is_circular
  input  logic [1:0]   s_axis_tuser_i,
  input  logic         s_axis_tlast_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // tdata, lowest bit up: distance[31:0]
  output logic [31:0]  m_axis_tdata_o,
  // tuser, lowest bit up: overflow
  output logic [0:0]   m_axis_tuser_o,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i
);

  localparam int unsigned W  = jsd_pkg::WORD_W;
  localparam int unsigned AW = jsd_pkg::ACC_W;
  localparam int unsigned DW = W + 3;

  localparam logic [63:0] PiFix64 =
    (jsd_pkg::PI_Q60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
  localparam logic [63:0] TwoPiFix64 =
    (jsd_pkg::PI_Q60 + (64'd1 << (58 - FRAC_BITS))) >> (59 - FRAC_BITS);
  localparam logic signed [DW-1:0] PiFix    = signed'(DW'(PiFix64));
  localparam logic signed [DW-1:0] TwoPiFix = signed'(DW'(TwoPiFix64));
  localparam logic [AW:0]          Half     = (AW+1)'(1) << (FRAC_BITS - 1);

  jsd_pkg::jsd_state_e state_q, state_d;

  logic signed [DW-1:0] d_q;
  logic                 ang_q;
  logic                 circ_q;
  logic                 last_q;
  logic [W-1:0]         wgt_q;
  logic [W-1:0]         mag_q;
  logic [AW-1:0]        term_q;
  logic [AW-1:0]        acc_q;
  logic                 sat_q;
  logic [1:0]           step_q;
  logic [W-1:0]         dist_q;
  logic                 ovf_q;

  logic                 in_xfer;
  logic                 out_xfer;
  logic [W-1:0]         mul_b;
  logic [2*W-1:0]       prod;
  logic                 sqrt_start;
  logic                 sqrt_done;
  logic [W-1:0]         root;

  logic signed [DW-1:0] diff;
  logic [DW-1:0]        d_abs;
  logic [AW:0]          rnd_sum;
  logic [AW:0]          rnd_shift;
  logic [AW:0]          acc_sum;
  logic                 wrap_lo;
  logic                 wrap_hi;
  logic                 root_big;

  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_xfer = m_axis_tvalid_o && m_axis_tready_i;

  // Difference of the two positions, sign extended
  assign diff = DW'($signed(s_axis_tdata_i[63:32])) - DW'($signed(s_axis_tdata_i[31:0]));
  assign d_abs = (d_q < 0) ? DW'(-d_q) : DW'(d_q);

  // Wrap tests: first two steps pull up from below -pi, last two pull down
  assign wrap_lo = (step_q[1] == 1'b0) && (d_q < -PiFix);
  assign wrap_hi = (step_q[1] == 1'b1) && (d_q > PiFix);

  // Round-half-up rescale of the registered product
  assign rnd_sum   = {1'b0, prod} + Half;
  assign rnd_shift = rnd_sum >> FRAC_BITS;
  assign acc_sum   = {1'b0, acc_q} + {1'b0, term_q};
  assign root_big  = (acc_q >> (AW - FRAC_BITS)) != '0;

  // Shared units
  jsd_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mag_q),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  jsd_isqrt u_isqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (sqrt_start),
    .operand_i (acc_q << FRAC_BITS),
    .done_o    (sqrt_done),
    .root_o    (root)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      jsd_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_d = (s_axis_tuser_i[0] && s_axis_tuser_i[1]) ? jsd_pkg::ST_WRAP
                                                             : jsd_pkg::ST_MAG;
        end
      end
      jsd_pkg::ST_WRAP: begin
        if (step_q == 2'd3) begin
          state_d = jsd_pkg::ST_MAG;
        end
      end
      jsd_pkg::ST_MAG: begin
        state_d = ang_q ? jsd_pkg::ST_MULW : jsd_pkg::ST_MULS;
      end
      jsd_pkg::ST_MULW: state_d = jsd_pkg::ST_RNDW;
      jsd_pkg::ST_RNDW: begin
        state_d = (rnd_shift[AW:W] != '0) ? jsd_pkg::ST_ACC : jsd_pkg::ST_MULS;
      end
      jsd_pkg::ST_MULS: state_d = jsd_pkg::ST_RNDS;
      jsd_pkg::ST_RNDS: state_d = jsd_pkg::ST_ACC;
      jsd_pkg::ST_ACC: begin
        state_d = last_q ? jsd_pkg::ST_FIN : jsd_pkg::ST_IDLE;
      end
      jsd_pkg::ST_FIN: begin
        state_d = root_big ? jsd_pkg::ST_OUT : jsd_pkg::ST_SQRT;
      end
      jsd_pkg::ST_SQRT: begin
        if (sqrt_done) begin
          state_d = jsd_pkg::ST_OUT;
        end
      end
      jsd_pkg::ST_OUT: begin
        if (out_xfer) begin
          state_d = jsd_pkg::ST_IDLE;
        end
      end
      default: state_d = jsd_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    m_axis_tvalid_o = 1'b0;
    mul_b           = mag_q;
    sqrt_start      = 1'b0;
    case (state_q)
      jsd_pkg::ST_IDLE: s_axis_tready_o = 1'b1;
      jsd_pkg::ST_MULW: mul_b = wgt_q;
      jsd_pkg::ST_FIN:  sqrt_start = !root_big;
      jsd_pkg::ST_OUT:  m_axis_tvalid_o = 1'b1;
      default: begin
        mul_b = mag_q;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jsd_pkg::ST_IDLE;
      step_q  <= '0;
      acc_q   <= '0;
      sat_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        jsd_pkg::ST_IDLE: step_q <= '0;
        jsd_pkg::ST_WRAP: step_q <= step_q + 2'd1;
        jsd_pkg::ST_RNDW: begin
          if (rnd_shift[AW:W] != '0) begin
            sat_q <= 1'b1;
          end
        end
        jsd_pkg::ST_ACC: begin
          if (acc_sum[AW]) begin
            acc_q <= '1;
            sat_q <= 1'b1;
          end else begin
            acc_q <= acc_sum[AW-1:0];
          end
        end
        jsd_pkg::ST_FIN: begin
          // Clear now if the result is final; else clear when the root lands
          if (root_big) begin
            acc_q <= '0;
            sat_q <= 1'b0;
          end
        end
        jsd_pkg::ST_SQRT: begin
          if (sqrt_done) begin
            acc_q <= '0;
            sat_q <= 1'b0;
          end
        end
        default: begin
          step_q <= step_q;
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      jsd_pkg::ST_IDLE: begin
        if (in_xfer) begin
          d_q    <= diff;
          ang_q  <= s_axis_tuser_i[0];
          circ_q <= s_axis_tuser_i[1];
          wgt_q  <= s_axis_tdata_i[95:64];
          last_q <= s_axis_tlast_i;
        end
      end
      jsd_pkg::ST_WRAP: begin
        if (circ_q && wrap_lo) begin
          d_q <= d_q + TwoPiFix;
        end else if (circ_q && wrap_hi) begin
          d_q <= d_q - TwoPiFix;
        end
      end
      jsd_pkg::ST_MAG: mag_q <= d_abs[W-1:0];
      jsd_pkg::ST_RNDW: begin
        if (rnd_shift[AW:W] != '0) begin
          term_q <= '1;
        end else begin
          mag_q <= rnd_shift[W-1:0];
        end
      end
      jsd_pkg::ST_RNDS: term_q <= rnd_shift[AW-1:0];
      jsd_pkg::ST_FIN: begin
        if (root_big) begin
          dist_q <= '1;
          ovf_q  <= 1'b1;
        end
      end
      jsd_pkg::ST_SQRT: begin
        if (sqrt_done) begin
          dist_q <= root;
          ovf_q  <= sat_q;
        end
      end
      default: begin
        mag_q <= mag_q;
      end
    endcase
  end

  assign m_axis_tdata_o = dist_q;
  assign m_axis_tuser_o = ovf_q;

endmodule

@@ test/distance_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// distance_checker: predicts and checks joint space distance results
// Watches both stream channels. Every input transfer is folded into a
// private copy of the squared-distance accumulator. Every tlast transfer
// queues the expected distance and overflow flag. Output transfers are
// compared in order against that queue.
// ----------------------------------------------------------------------------
module distance_checker #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata, lowest bit up: start_position[31:0], end_position[31:0],
  // joint_weight[31:0]
  input  logic [95:0] s_tdata_i,
  // tuser, lowest bit up: is_angular, is_circular
  input  logic [1:0]  s_tuser_i,
  input  logic        s_tlast_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  // tdata, lowest bit up: distance[31:0]
  input  logic [31:0] m_tdata_i,
  // tuser, lowest bit up: overflow
  input  logic [0:0]  m_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  output int          fail_count_o,
  output int          pending_o
);

  // Pi and 2 pi rounded to nearest at the working scale
  localparam logic signed [63:0] PI_FIX =
    (jsd_pkg::PI_Q60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
  localparam logic signed [63:0] TWO_PI_FIX =
    (jsd_pkg::PI_Q60 + (64'd1 << (58 - FRAC_BITS))) >> (59 - FRAC_BITS);
  localparam logic [63:0] HALF_LSB = 64'd1 << (FRAC_BITS - 1);
  localparam logic [63:0] ALL_ONES = '1;

  typedef struct packed {
    logic [31:0] distance;
    logic        overflow;
  } dist_result_t;

  dist_result_t expected_dist_q[$];
  dist_result_t head;
  logic [63:0]  sq_sum;
  logic         sq_sat;

  // Integer square root, one result bit per pass
  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bitv;
    rem  = v;
    res  = '0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Fold one joint into the running sum; queue a distance on tlast
  task automatic fold_joint(input logic [95:0] data, input logic [1:0] user,
                            input logic last);
    logic signed [63:0] diff;
    logic [63:0]        mag;
    logic [63:0]        term;
    dist_result_t       res;
    diff = longint'($signed(data[63:32])) - longint'($signed(data[31:0]));
    // Wrap circular angles, at most two corrections each way
    if (user[0] && user[1]) begin
      repeat (2) if (diff < -PI_FIX) diff = diff + TWO_PI_FIX;
      repeat (2) if (diff > PI_FIX) diff = diff - TWO_PI_FIX;
    end
    mag = (diff < 0) ? 64'(-diff) : 64'(diff);
    if (user[0]) mag = (mag * {32'd0, data[95:64]} + HALF_LSB) >> FRAC_BITS;
    if (mag > 64'hFFFF_FFFF) begin
      term   = ALL_ONES;
      sq_sat = 1'b1;
    end else begin
      term = (mag * mag + HALF_LSB) >> FRAC_BITS;
    end
    if (sq_sum > ALL_ONES - term) begin
      sq_sum = ALL_ONES;
      sq_sat = 1'b1;
    end else begin
      sq_sum = sq_sum + term;
    end
    if (last) begin
      if (sq_sum > (ALL_ONES >> FRAC_BITS)) begin
        res.distance = 32'hFFFF_FFFF;
        sq_sat       = 1'b1;
      end else begin
        res.distance = 32'(int_sqrt(sq_sum << FRAC_BITS));
      end
      res.overflow = sq_sat;
      expected_dist_q.push_back(res);
      sq_sum = '0;
      sq_sat = 1'b0;
    end
  endtask

  // Compare output transfers first, then predict from input transfers
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_dist_q.delete();
      sq_sum       = '0;
      sq_sat       = 1'b0;
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (expected_dist_q.size() == 0) begin
          if (fail_count_o < 10)
            $display("%0t: unexpected result distance %h overflow %b",
                     $realtime, m_tdata_i, m_tuser_i[0]);
          fail_count_o = fail_count_o + 1;
        end else begin
          head = expected_dist_q.pop_front();
          if (head.distance !== m_tdata_i || head.overflow !== m_tuser_i[0]) begin
            if (fail_count_o < 10)
              $display("%0t: mismatch, expected distance %h overflow %b, got %h %b",
                       $realtime, head.distance, head.overflow, m_tdata_i,
                       m_tuser_i[0]);
            fail_count_o = fail_count_o + 1;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) fold_joint(s_tdata_i, s_tuser_i, s_tlast_i);
      pending_o = expected_dist_q.size();
    end
  end

endmodule

@@ test/joint_space_distance_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// joint_space_distance_test: stimulus and verdict for the distance block
// Feeds directed corner joints, then random configurations under three
// backpressure profiles, and lets the checker judge every result.
// ----------------------------------------------------------------------------
module joint_space_distance_test;

  localparam int unsigned FRAC_BITS      = 16;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          ITEMS_PER_PHASE = 185;
  // Pi and 2 pi at Q15.16 for directed angles
  localparam logic [31:0] PI_Q16 = 32'((jsd_pkg::PI_Q60 + (64'd1 << 43)) >> 44);
  localparam int          TWO_PI_Q16 = 411775;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic [95:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = '0;
  logic        s_tlast  = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] m_axis_tdata_o;
  logic [0:0]  m_axis_tuser_o;
  logic        m_axis_tvalid_o;
  logic        m_tready = 1'b0;

  int send_idle = 0;
  int recv_idle = 0;
  int idle_cycles = 0;
  int fail_count;
  int pending;

  joint_space_distance #(.FRAC_BITS(FRAC_BITS)) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready)
  );

  distance_checker #(.FRAC_BITS(FRAC_BITS)) dist_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .s_tlast_i    (s_tlast),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_axis_tready_o),
    .m_tdata_i    (m_axis_tdata_o),
    .m_tuser_i    (m_axis_tuser_o),
    .m_tvalid_i   (m_axis_tvalid_o),
    .m_tready_i   (m_tready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #6 clk_i = ~clk_i;

  // Stall the result channel at the current rate
  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(99) >= recv_idle);
  end

  // Count cycles without any transfer and give up past the limit
  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL joint_space_distance");
      $finish;
    end
  end

  // Present one joint, with an optional random gap first; return after transfer
  task automatic send_joint(input logic [31:0] start_pos, input logic [31:0] end_pos,
                            input logic angular, input logic circular,
                            input logic [31:0] weight, input logic last);
    if ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle) @(posedge clk_i);
    end
    s_tdata  <= {weight, end_pos, start_pos};
    s_tuser  <= {circular, angular};
    s_tlast  <= last;
    s_tvalid <= 1'b1;
    @(negedge clk_i);
    while (!s_axis_tready_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin
    int          send_pct[3];
    int          recv_pct[3];
    int          sent;
    int          count;
    int          kind;
    logic [31:0] sp;
    logic [31:0] ep;
    logic [31:0] w;
    send_pct = '{31, 84, 0};
    recv_pct = '{84, 31, 0};
    send_idle = send_pct[0];
    recv_idle = recv_pct[0];

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero distance, single joint
    send_joint(32'd0, 32'd0, 1'b0, 1'b0, 32'd0, 1'b1);
    // Full span of the position range, both signs
    send_joint(32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'd0, 1'b1);
    send_joint(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 32'hFFFF_FFFF, 1'b1);
    // Two full spans overflow the root
    send_joint(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 32'hFFFF_FFFF, 1'b0);
    send_joint(32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'd0, 1'b1);
    // Angular, unit weight
    send_joint(32'd0, PI_Q16, 1'b1, 1'b0, 32'h0001_0000, 1'b1);
    // Wrapped both ways, then circular without angular
    send_joint(32'd0, PI_Q16 + (PI_Q16 >> 1), 1'b1, 1'b1, 32'h0001_0000, 1'b0);
    send_joint(32'd0, -(PI_Q16 + (PI_Q16 >> 1)), 1'b1, 1'b1, 32'h0001_0000, 1'b0);
    send_joint(32'd0, 3 * PI_Q16, 1'b0, 1'b1, 32'h0003_0000, 1'b1);
    // Seven pi apart: still beyond pi after two corrections
    send_joint(-((7 * PI_Q16) >> 1), (7 * PI_Q16) >> 1, 1'b1, 1'b1, 32'h0001_0000, 1'b0);
    send_joint((7 * PI_Q16) >> 1, -((7 * PI_Q16) >> 1), 1'b1, 1'b1, 32'h0001_0000, 1'b1);
    // Exactly at and just past the wrap threshold
    send_joint(32'd0, PI_Q16, 1'b1, 1'b1, 32'h0001_0000, 1'b0);
    send_joint(32'd0, -PI_Q16, 1'b1, 1'b1, 32'h0001_0000, 1'b0);
    send_joint(32'd0, PI_Q16 + 1, 1'b1, 1'b1, 32'h0001_0000, 1'b0);
    send_joint(32'd0, -(PI_Q16 + 1), 1'b1, 1'b1, 32'h0001_0000, 1'b1);
    // Saturated term, then a full accumulator
    send_joint(32'd0, 32'h7FFF_FFFF, 1'b1, 1'b0, 32'hFFFF_FFFF, 1'b0);
    send_joint(32'd0, 32'd1, 1'b0, 1'b0, 32'd0, 1'b1);
    // Zero weight, and full range with full weight under wrap
    send_joint(32'd12345, -32'd54321, 1'b1, 1'b1, 32'd0, 1'b1);
    send_joint(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1);
    send_joint(32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 1'b0, 32'h0000_8000, 1'b1);

    // Random configurations under each backpressure profile
    for (int phase = 0; phase < 3; phase++) begin
      send_idle = send_pct[phase];
      recv_idle = recv_pct[phase];
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        count = $urandom_range(7, 1);
        for (int j = 0; j < count; j++) begin
          kind = $urandom_range(3);
          if ($urandom_range(7) == 0) begin
            sp = $urandom();
            ep = $urandom();
          end else if (kind == 0) begin
            sp = $urandom_range(32'h0020_0000) - 32'h0010_0000;
            ep = $urandom_range(32'h0020_0000) - 32'h0010_0000;
          end else begin
            sp = $urandom_range(2 * TWO_PI_Q16) - TWO_PI_Q16;
            ep = $urandom_range(2 * TWO_PI_Q16) - TWO_PI_Q16;
          end
          w = ($urandom_range(7) == 0) ? $urandom() : $urandom_range(32'h0004_0000);
          send_joint(sp, ep, kind == 1 || kind == 2, kind >= 2, w, j == count - 1);
          sent++;
        end
      end
    end
    s_tvalid <= 1'b0;

    // Drain outstanding results, then allow the sequencer to settle
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (64) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("PASS joint_space_distance");
    end else begin
      $display("FAIL joint_space_distance");
    end
    $finish;
  end

endmodule
